// File: rtl/bounded_deque_list_engine_assert.svh
// Assertion macros used by the checker file of the deque list engine.
`ifndef BOUNDED_DEQUE_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_DEQUE_LIST_ENGINE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BDLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in the next cycle follows from a condition now.
`define BDLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bdle_pkg.sv
// Shared types and constants of the deque list engine.
package bdle_pkg;

  typedef logic signed [31:0] data_t;

  localparam int MAX_RESULTS = 32;

  typedef enum logic [3:0] {
    ACT_PUSH_FRONT  = 4'd0,
    ACT_PUSH_BACK   = 4'd1,
    ACT_POP_FRONT   = 4'd2,
    ACT_POP_BACK    = 4'd3,
    ACT_DROP_LAST   = 4'd4,
    ACT_REMOVE_2ND  = 4'd5,
    ACT_PUSH_COUNT  = 4'd6,
    ACT_PUSH_RANGE  = 4'd7,
    ACT_INSERT_PEN  = 4'd8,
    ACT_DUMP        = 4'd9
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_SHORT    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // What every cell of the chain does at a clock edge.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_REMOVE_2ND,
    CMD_INSERT_PEN,
    CMD_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    data_t     value;
    data_t     head;
  } cell_ctl_t;

endpackage

// File: rtl/bdle_cell.sv
// One storage cell of the list chain; holds the element at position IDX.
module bdle_cell #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic                clk,
  input  bdle_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]       list_count,
  input  logic [CW-1:0]       last_idx,
  input  bdle_pkg::data_t     left,
  input  bdle_pkg::data_t     right,
  output bdle_pkg::data_t     q
);
  import bdle_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  data_t q_next;

  always_comb begin
    q_next = q;
    unique case (ctl.cmd)
      CMD_HOLD:       q_next = q;
      CMD_PUSH_FRONT: q_next = (IDX == 0) ? ctl.value : left;
      CMD_PUSH_BACK:  q_next = (MY_IDX == list_count) ? ctl.value : q;
      CMD_POP_FRONT:  q_next = right;
      CMD_REMOVE_2ND: q_next = (IDX == 0) ? q : right;
      CMD_INSERT_PEN: begin
        if (MY_IDX == last_idx) q_next = ctl.value;
        else if (MY_IDX == list_count) q_next = left;
      end
      CMD_ROTATE: begin
        // rotate the occupied part: the front wraps to the last place
        if (MY_IDX < last_idx) q_next = right;
        else if (MY_IDX == last_idx) q_next = ctl.head;
      end
      default:        q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// File: rtl/bounded_deque_list_engine.sv
// Top level of the bounded deque list engine: sequencer, cell chain, result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------------
//   in      | in        | in_valid / in_stall  | action, operand
//   out     | out       | out_valid / out_stall| status, count, front_value, back_value,
//           |           |                      | element_value, element_present, last
//
// Single-element actions update the cell chain, then load the report into the output
// register once it is free. Push range pushes one value per cycle after the accept,
// then makes the closing check and loads the report. Dump rotates the occupied cells
// of the chain once per cycle, waiting on a stalled output while it still emits, and
// emits the front cell each time up to 32; a longer list rotates on silently until restored.
// Reset (rst, synchronous) empties the list and clears the sequencer and output valid.
// A stalled output holds its word; a new input word is taken while it waits.
module bounded_deque_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [3:0]      action,
  input  bdle_pkg::data_t operand,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      status,
  output logic [5:0]      count,
  output bdle_pkg::data_t front_value,
  output bdle_pkg::data_t back_value,
  output bdle_pkg::data_t element_value,
  output logic            element_present,
  output logic            last
);
  import bdle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);   // element count
  localparam int AW = $clog2(CAPACITY);       // cell position
  localparam int IW = $clog2(CAPACITY + 2);   // push range value
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE        = CW'(1);

  typedef enum logic [1:0] {S_IDLE, S_RANGE, S_DUMP} state_t;

  // sequencer registers
  state_t        state, state_next;
  logic [CW-1:0] list_count, list_count_next;
  logic          pend, pend_next;
  status_t       pend_status, pend_status_next;
  logic [IW-1:0] range_i, range_i_next;
  logic [31:0]   range_n, range_n_next;
  logic [CW-1:0] dump_k, dump_k_next;
  data_t         dump_front, dump_front_next;
  data_t         dump_back, dump_back_next;

  // output register next values
  logic          out_valid_next;
  logic [1:0]    status_next;
  logic [5:0]    count_next;
  data_t         front_next, back_next, element_next;
  logic          present_next, last_next;

  // chain
  data_t         cell_q [CAPACITY];
  cell_ctl_t     ctl;
  logic [CW-1:0] last_idx;
  data_t         back_cur;
  data_t         front_rpt, back_rpt;
  logic [CW+5:0] count_wide;

  logic          in_accept, out_free;
  logic          full, empty, too_short;
  logic [31:0]   op_u, count32, k1;
  logic          range_more;

  assign in_stall  = (state != S_IDLE) || pend;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign last_idx   = list_count - ONE;
  assign back_cur   = cell_q[last_idx[AW-1:0]];
  assign front_rpt  = (list_count != '0) ? cell_q[0] : '0;
  assign back_rpt   = (list_count != '0) ? back_cur : '0;
  assign count_wide = {6'd0, list_count};

  assign full      = (list_count == FULL_COUNT);
  assign empty     = (list_count == '0);
  assign too_short = (list_count <= ONE);
  assign op_u      = operand;
  assign count32   = 32'(list_count);
  assign k1        = 32'(dump_k) + 32'd1;
  assign range_more = (32'(range_i) <= range_n);

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      data_t left_d, right_d;
      if (g == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_inner_l
        assign left_d = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_end
        assign right_d = '0;
      end else begin : g_inner_r
        assign right_d = cell_q[g+1];
      end
      bdle_cell #(.IDX(g), .CW(CW)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .list_count (list_count),
        .last_idx   (last_idx),
        .left       (left_d),
        .right      (right_d),
        .q          (cell_q[g])
      );
    end
  endgenerate

  always_comb begin
    ctl.cmd          = CMD_HOLD;
    ctl.value        = operand;
    ctl.head         = cell_q[0];
    state_next       = state;
    list_count_next  = list_count;
    pend_next        = pend;
    pend_status_next = pend_status;
    range_i_next     = range_i;
    range_n_next     = range_n;
    dump_k_next      = dump_k;
    dump_front_next  = dump_front;
    dump_back_next   = dump_back;

    out_valid_next   = out_valid && out_stall;
    status_next      = status;
    count_next       = count;
    front_next       = front_value;
    back_next        = back_value;
    element_next     = element_value;
    present_next     = element_present;
    last_next        = last;

    // report of a finished single-word action
    if (pend && out_free) begin
      pend_next      = 1'b0;
      out_valid_next = 1'b1;
      status_next    = pend_status;
      count_next     = count_wide[5:0];
      front_next     = front_rpt;
      back_next      = back_rpt;
      element_next   = '0;
      present_next   = 1'b0;
      last_next      = 1'b1;
    end

    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          pend_next        = 1'b1;
          pend_status_next = ST_DONE;
          unique case (action)
            ACT_PUSH_FRONT: begin
              if (full) pend_status_next = ST_OVERFLOW;
              else begin
                ctl.cmd         = CMD_PUSH_FRONT;
                list_count_next = list_count + ONE;
              end
            end
            ACT_PUSH_BACK: begin
              if (full) pend_status_next = ST_OVERFLOW;
              else begin
                ctl.cmd         = CMD_PUSH_BACK;
                list_count_next = list_count + ONE;
              end
            end
            ACT_POP_FRONT: begin
              if (empty) pend_status_next = ST_SHORT;
              else begin
                ctl.cmd         = CMD_POP_FRONT;
                list_count_next = list_count - ONE;
              end
            end
            ACT_POP_BACK: begin
              if (empty) pend_status_next = ST_SHORT;
              else list_count_next = list_count - ONE;
            end
            ACT_DROP_LAST: begin
              // negative N drops nothing
              if (!operand[31]) begin
                if (op_u >= count32) list_count_next = '0;
                else list_count_next = list_count - op_u[CW-1:0];
              end
            end
            ACT_REMOVE_2ND: begin
              if (too_short) pend_status_next = ST_SHORT;
              else begin
                ctl.cmd         = CMD_REMOVE_2ND;
                list_count_next = list_count - ONE;
              end
            end
            ACT_PUSH_COUNT: begin
              if (full) pend_status_next = ST_OVERFLOW;
              else begin
                ctl.cmd         = CMD_PUSH_BACK;
                ctl.value       = data_t'(count32);
                list_count_next = list_count + ONE;
              end
            end
            ACT_PUSH_RANGE: begin
              if (!operand[31]) begin
                pend_next    = 1'b0;
                state_next   = S_RANGE;
                range_i_next = IW'(1);
                range_n_next = op_u;
              end
            end
            ACT_INSERT_PEN: begin
              if (too_short) pend_status_next = ST_SHORT;
              else if (full) pend_status_next = ST_OVERFLOW;
              else begin
                ctl.cmd         = CMD_INSERT_PEN;
                list_count_next = list_count + ONE;
              end
            end
            ACT_DUMP: begin
              // an empty list answers with one plain report
              if (!empty) begin
                pend_next       = 1'b0;
                state_next      = S_DUMP;
                dump_k_next     = '0;
                dump_front_next = cell_q[0];
                dump_back_next  = back_cur;
              end
            end
            default: ;
          endcase
        end
      end

      S_RANGE: begin
        if (range_more && !full) begin
          ctl.cmd         = CMD_PUSH_BACK;
          ctl.value       = data_t'(32'(range_i));
          list_count_next = list_count + ONE;
          range_i_next    = range_i + IW'(1);
        end else begin
          pend_next        = 1'b1;
          pend_status_next = range_more ? ST_OVERFLOW : ST_DONE;
          state_next       = S_IDLE;
        end
      end

      S_DUMP: begin
        // emit while under the result limit, then rotate on silently
        if ((32'(dump_k) >= 32'(MAX_RESULTS)) || out_free) begin
          ctl.cmd     = CMD_ROTATE;
          dump_k_next = dump_k + ONE;
          if (k1 == count32) state_next = S_IDLE;
          if (32'(dump_k) < 32'(MAX_RESULTS)) begin
            out_valid_next = 1'b1;
            status_next    = ST_DONE;
            count_next     = count_wide[5:0];
            front_next     = dump_front;
            back_next      = dump_back;
            element_next   = cell_q[0];
            present_next   = 1'b1;
            last_next      = (k1 == count32) || (k1 == 32'(MAX_RESULTS));
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      list_count  <= '0;
      pend        <= 1'b0;
      pend_status <= ST_DONE;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      list_count  <= list_count_next;
      pend        <= pend_next;
      pend_status <= pend_status_next;
      out_valid   <= out_valid_next;
    end
    range_i         <= range_i_next;
    range_n         <= range_n_next;
    dump_k          <= dump_k_next;
    dump_front      <= dump_front_next;
    dump_back       <= dump_back_next;
    status          <= status_next;
    count           <= count_next;
    front_value     <= front_next;
    back_value      <= back_next;
    element_value   <= element_next;
    element_present <= present_next;
    last            <= last_next;
  end

endmodule

// File: rtl/bdle_checker.sv
// Port-level checks of the deque list engine, bound to the top level.
module bdle_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [5:0]  count,
  input logic [31:0] element_value,
  input logic        element_present,
  input logic        last
);

`include "bounded_deque_list_engine_assert.svh"

  // a stalled output word holds
  `BDLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(count) && $stable(element_value) && $stable(last), "stalled output word changed")
  // every accepted word stalls the input in the cycle after it is taken
  `BDLE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken on back-to-back cycles")
  `BDLE_ASSERT(a_report_shape, !(out_valid && !element_present) || (element_value == 32'd0 && last), "report word carries an element")
  `BDLE_ASSERT(a_dump_status, !(out_valid && element_present) || (status == 2'd0), "dump word with nonzero status")
  `BDLE_ASSERT(a_status_code, !out_valid || (status != 2'd3), "undefined status code")

endmodule

bind bounded_deque_list_engine bdle_checker u_bdle_checker (.*);

// File: tb/bounded_deque_list_engine_tb.sv
// Self-checking testbench for the bounded deque list engine: directed, backpressure and random.
module bounded_deque_list_engine_tb;
  import bdle_pkg::*;

  // Size the list as the block's default build does.
  localparam int CAPACITY = 32;
  // Cycles to keep watching the output once nothing is expected: one full dump and then some.
  localparam int DRAIN_CYCLES = 40;
  // Highest code the action field can carry; codes above ACT_DUMP are unused.
  localparam logic [3:0] ACT_LAST_CODE = 4'hF;
  localparam data_t DATA_MAX = 32'sh7fff_ffff;
  localparam data_t DATA_MIN = 32'sh8000_0000;

  // One output word as the block should present it.
  typedef struct {
    status_t    status;
    logic [5:0] count;
    data_t      front;
    data_t      back;
    data_t      elem;
    logic       present;
    logic       last;
  } list_report_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [3:0] action;
  data_t      operand;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] status;
  logic [5:0] count;
  data_t      front_value;
  data_t      back_value;
  data_t      element_value;
  logic       element_present;
  logic       last;

  // Contents of the list, front first, as the block should hold it.
  data_t        list_model[$];
  // Output words still owed by the block, oldest first.
  list_report_t expected_reports[$];

  // Idling odds, in percent per cycle, for each side.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Long hold-off: the test posts a length and bumps the request count, the receiver
  // process takes it up and counts it down.
  int hold_len   = 0;
  int hold_reqs  = 0;
  int hold_taken = 0;
  int hold_left  = 0;

  int err_cnt       = 0;
  int words_sent    = 0;
  int reports_seen  = 0;
  int dump_words    = 0;
  int overflow_cnt  = 0;
  int short_cnt     = 0;

  bounded_deque_list_engine #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .operand        (operand),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .count          (count),
    .front_value    (front_value),
    .back_value     (back_value),
    .element_value  (element_value),
    .element_present(element_present),
    .last           (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // List predictor
  // ---------------------------------------------------------------------------

  // Build the word the block reports for the list as it stands now.
  function automatic list_report_t report_of(status_t st, data_t elem, logic present,
                                             logic last_flag);
    list_report_t r;
    int n;
    n         = list_model.size();
    r.status  = st;
    r.count   = n[5:0];
    r.front   = (n != 0) ? list_model[0] : '0;
    r.back    = (n != 0) ? list_model[n-1] : '0;
    r.elem    = elem;
    r.present = present;
    r.last    = last_flag;
    return r;
  endfunction

  // Apply one accepted word to the list and queue the words it should produce.
  function automatic void apply_list_action(logic [3:0] act, data_t opnd);
    status_t st;
    int room;
    int n;
    st   = ST_DONE;
    room = CAPACITY - list_model.size();
    case (act)
      ACT_PUSH_FRONT: begin
        if (room == 0) st = ST_OVERFLOW;
        else list_model.push_front(opnd);
      end
      ACT_PUSH_BACK: begin
        if (room == 0) st = ST_OVERFLOW;
        else list_model.push_back(opnd);
      end
      ACT_POP_FRONT: begin
        if (list_model.size() == 0) st = ST_SHORT;
        else void'(list_model.pop_front());
      end
      ACT_POP_BACK: begin
        if (list_model.size() == 0) st = ST_SHORT;
        else void'(list_model.pop_back());
      end
      ACT_DROP_LAST: begin
        // A negative count drops nothing; a count past the end empties the list.
        if (opnd >= 0) begin
          if (opnd >= list_model.size()) list_model.delete();
          else repeat (opnd) void'(list_model.pop_back());
        end
      end
      ACT_REMOVE_2ND: begin
        if (list_model.size() <= 1) st = ST_SHORT;
        else list_model.delete(1);
      end
      ACT_PUSH_COUNT: begin
        if (room == 0) st = ST_OVERFLOW;
        else list_model.push_back(data_t'(list_model.size()));
      end
      ACT_PUSH_RANGE: begin
        // Push 1..N; values that find the list full are lost.
        if (opnd > 0) begin
          n = (opnd > room) ? room : opnd;
          for (int i = 1; i <= n; i++) list_model.push_back(data_t'(i));
          if (opnd > room) st = ST_OVERFLOW;
        end
      end
      ACT_INSERT_PEN: begin
        // The short-list test wins over the full-list test.
        if (list_model.size() <= 1) st = ST_SHORT;
        else if (room == 0) st = ST_OVERFLOW;
        else list_model.insert(list_model.size() - 1, opnd);
      end
      ACT_DUMP: begin
        n = (list_model.size() > MAX_RESULTS) ? MAX_RESULTS : list_model.size();
        if (n == 0) begin
          expected_reports.push_back(report_of(ST_DONE, '0, 1'b0, 1'b1));
        end else begin
          for (int k = 0; k < n; k++)
            expected_reports.push_back(report_of(ST_DONE, list_model[k], 1'b1, k == n - 1));
        end
        return;
      end
      default: ;
    endcase
    if (st == ST_OVERFLOW) overflow_cnt++;
    if (st == ST_SHORT) short_cnt++;
    expected_reports.push_back(report_of(st, '0, 1'b0, 1'b1));
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one word, idle first at random, and hold it until the block takes it.
  task automatic send_word(input logic [3:0] act, input data_t opnd);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action   = act;
    operand  = opnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_list_action(act, opnd);
    words_sent++;
  endtask

  // Drop valid, wait until every owed word has come out, then watch a while longer.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Lean on the extremes and the sign boundary, else any 32-bit value.
  function automatic data_t pick_value();
    case ($urandom_range(7))
      0: return DATA_MAX;
      1: return DATA_MIN;
      2: return '0;
      3: return -1;
      default: return data_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Stall at random, or hold off for a posted stretch of cycles.
  always @(negedge clk) begin
    if (hold_taken != hold_reqs) begin
      hold_taken = hold_reqs;
      hold_left  = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compare each accepted output word with the oldest owed one.
  always @(posedge clk) begin : check_reports
    list_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected output word, expected none, actual status %h count %0d",
                 $time, status, count);
      end else begin
        want = expected_reports.pop_front();
        reports_seen++;
        if (want.present) dump_words++;
        check_field("status", 32'(want.status), 32'(status));
        check_field("count", 32'(want.count), 32'(count));
        check_field("front_value", want.front, front_value);
        check_field("back_value", want.back, back_value);
        check_field("element_value", want.elem, element_value);
        check_field("element_present", 32'(want.present), 32'(element_present));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Dump and removals on an empty list.
  task automatic test_empty_list();
    send_word(ACT_DUMP, '0);
    send_word(ACT_POP_FRONT, 32'sd5);
    send_word(ACT_POP_BACK, '0);
    send_word(ACT_REMOVE_2ND, '0);
    wait_drained();
  endtask

  // Every single-element action but drop last at least once, with extreme values, plus a push range and a dump.
  task automatic test_basic_actions();
    send_word(ACT_PUSH_BACK, DATA_MAX);
    send_word(ACT_INSERT_PEN, 32'sd77);      // one element: too short
    send_word(ACT_PUSH_FRONT, DATA_MIN);
    send_word(ACT_PUSH_COUNT, '0);
    send_word(ACT_INSERT_PEN, -1);
    send_word(ACT_REMOVE_2ND, '0);
    send_word(ACT_PUSH_RANGE, 32'sd3);
    send_word(ACT_DUMP, '0);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_POP_BACK, '0);
    wait_drained();
  endtask

  // Drop last with a negative count, then with one.
  task automatic test_drop_extremes();
    send_word(ACT_DROP_LAST, -1);
    send_word(ACT_DROP_LAST, 32'sd1);
    wait_drained();
  endtask

  task automatic test_unused_actions();
    send_word(4'(ACT_DUMP + 1), DATA_MAX);
    send_word(ACT_LAST_CODE, DATA_MIN);
    wait_drained();
  endtask

  // Overfill with one push range, bounce every insert off the full list, dump it, empty it.
  task automatic test_full_list();
    send_word(ACT_PUSH_RANGE, 32'sd40);
    send_word(ACT_PUSH_FRONT, 32'sd11);
    send_word(ACT_PUSH_BACK, 32'sd12);
    send_word(ACT_PUSH_COUNT, '0);
    send_word(ACT_INSERT_PEN, 32'sd13);
    send_word(ACT_DUMP, '0);
    send_word(ACT_DROP_LAST, DATA_MAX);
    wait_drained();
  endtask

  // Pick one random word, shaped to keep the list mostly partly full.
  task automatic send_random_word();
    int pick;
    logic [3:0] act;
    data_t opnd;
    pick = $urandom_range(99);
    opnd = pick_value();
    // Trim a nearly full list more often than not.
    if (list_model.size() >= CAPACITY - 4 && $urandom_range(1) == 1) pick = 55;
    if (pick < 15) act = ACT_PUSH_FRONT;
    else if (pick < 30) act = ACT_PUSH_BACK;
    else if (pick < 40) act = ACT_POP_FRONT;
    else if (pick < 50) act = ACT_POP_BACK;
    else if (pick < 60) begin
      act = ACT_DROP_LAST;
      case ($urandom_range(9))
        7: opnd = -data_t'($urandom_range(100, 1));
        8: opnd = data_t'($urandom);
        9: opnd = data_t'($urandom_range(40, list_model.size()));
        default: opnd = data_t'($urandom_range(6));
      endcase
    end
    else if (pick < 68) act = ACT_REMOVE_2ND;
    else if (pick < 74) act = ACT_PUSH_COUNT;
    else if (pick < 80) begin
      act = ACT_PUSH_RANGE;
      case ($urandom_range(9))
        7: opnd = -data_t'($urandom_range(100, 1));
        8: opnd = data_t'($urandom_range(40, 30));
        9: ;
        default: opnd = data_t'($urandom_range(6));
      endcase
    end
    else if (pick < 88) act = ACT_INSERT_PEN;
    else if (pick < 96) act = ACT_DUMP;
    else act = 4'($urandom_range(int'(ACT_LAST_CODE), int'(ACT_DUMP) + 1));
    send_word(act, opnd);
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so the
  // block fills its output and must stall its input.
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_len = 300;
    hold_reqs++;
    repeat (20) send_random_word();
    wait_drained();
  endtask

  // Random traffic through every idling pattern.
  task automatic test_random_traffic(input int per_phase);
    set_idling(0, 0);
    repeat (per_phase) send_random_word();
    wait_drained();
    set_idling(82, 0);
    repeat (per_phase) send_random_word();
    wait_drained();
    set_idling(0, 82);
    repeat (per_phase) send_random_word();
    wait_drained();
    set_idling(10, 10);
    repeat (per_phase) send_random_word();
    wait_drained();
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = ACT_PUSH_FRONT;
    operand   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_basic_actions();
    test_drop_extremes();
    test_unused_actions();
    test_full_list();
    test_backpressure();
    test_random_traffic(45);

    $display("Sent %0d words, checked %0d output words (%0d dumped elements).",
             words_sent, reports_seen, dump_words);
    $display("Saw %0d overflow and %0d too-short answers across all idling patterns.",
             overflow_cnt, short_cnt);
    if (err_cnt == 0) begin
      $display("bounded_deque_list_engine_tb: clean");
    end else begin
      $display("bounded_deque_list_engine_tb: errors");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2000000;
    $display("bounded_deque_list_engine_tb: errors");
    $finish;
  end

endmodule
